// ----- hdl/uart_fifo_xon_xoff_flow_unit_defines.svh -----
// assertion macros for the flow unit checker
`ifndef UART_FIFO_XON_XOFF_FLOW_UNIT_DEFINES_SVH
`define UART_FIFO_XON_XOFF_FLOW_UNIT_DEFINES_SVH

// clocked assertion, off while reset is held
`define UFLOW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also watches the cycles around reset
`define UFLOW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/uflow_pkg.sv -----
// shared types, codes and constants of the xon/xoff flow unit
`default_nettype none

package uflow_pkg;

    localparam int DEF_RX_DEPTH = 64;
    localparam int DEF_TX_DEPTH = 64;

    localparam int THR_W   = 7;
    localparam int COUNT_W = 7;

    localparam logic [THR_W-1:0] THR_RESET = 7'd16;

    localparam logic [2:0] MODE_RX_BYTE = 3'd0;
    localparam logic [2:0] MODE_HOST_WR = 3'd1;
    localparam logic [2:0] MODE_HOST_RD = 3'd2;
    localparam logic [2:0] MODE_TX_RDY  = 3'd3;
    localparam logic [2:0] MODE_POLL    = 3'd4;

    localparam int FLG_REQ_XOFF = 0;
    localparam int FLG_XOFF_OUT = 1;
    localparam int FLG_REQ_XON  = 2;

    localparam logic [2:0] FLOW_RESET    = 3'b100;
    localparam logic [2:0] FLOW_XOFF_OUT = 3'b010;
    localparam logic [2:0] FLOW_NONE     = 3'b000;

    localparam logic [7:0] CHAR_XOFF = 8'h13;
    localparam logic [7:0] CHAR_XON  = 8'h11;

    // result of one request while the fifo read data is still in flight
    typedef struct packed {
        logic               line_valid;
        logic               line_from_mem;
        logic [7:0]         line_char;
        logic               read_valid;
        logic               write_accepted;
        logic [COUNT_W-1:0] rx_count;
        logic               rx_overflow;
    } t_pend;

endpackage

`default_nettype wire

// ----- hdl/uflow_ram.sv -----
// byte memory with one write port and one registered read port
`default_nettype none

module uflow_ram import uflow_pkg::*; #(
    parameter int DEPTH = DEF_RX_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/uflow_ctrl.sv -----
// fifo pointers, fill counts, flow flags and threshold register
`default_nettype none

module uflow_ctrl import uflow_pkg::*; #(
    parameter int RX_DEPTH = DEF_RX_DEPTH,
    parameter int TX_DEPTH = DEF_TX_DEPTH,
    parameter int RX_AW    = $clog2(RX_DEPTH),
    parameter int TX_AW    = $clog2(TX_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata,
    input  wire logic             i_acc,
    input  wire logic [2:0]       i_mode,
    output logic                  o_rx_we,
    output logic      [RX_AW-1:0] o_rx_waddr,
    output logic                  o_rx_re,
    output logic      [RX_AW-1:0] o_rx_raddr,
    output logic                  o_tx_we,
    output logic      [TX_AW-1:0] o_tx_waddr,
    output logic                  o_tx_re,
    output logic      [TX_AW-1:0] o_tx_raddr,
    output t_pend                 o_pend
);

    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    localparam int CMP_W = (RX_FW > THR_W) ? RX_FW : THR_W;

    logic [RX_AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [RX_FW-1:0] r_rx_fill, n_rx_fill;
    logic [TX_AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [TX_FW-1:0] r_tx_fill, n_tx_fill;
    logic [2:0]       r_flags, n_flags;
    logic             r_ovf, n_ovf;
    logic [THR_W-1:0] r_thr;

    logic rx_full, rx_empty, tx_full, tx_empty, over_thr;

    assign rx_full  = (r_rx_fill == RX_FW'(RX_DEPTH));
    assign rx_empty = (r_rx_fill == '0);
    assign tx_full  = (r_tx_fill == TX_FW'(TX_DEPTH));
    assign tx_empty = (r_tx_fill == '0);
    assign over_thr = (CMP_W'(r_rx_fill) > CMP_W'(r_thr));

    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_rx_fill  = r_rx_fill;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_fill  = r_tx_fill;
        n_flags    = r_flags;
        n_ovf      = r_ovf;
        o_rx_we    = 1'b0;
        o_rx_re    = 1'b0;
        o_tx_we    = 1'b0;
        o_tx_re    = 1'b0;
        o_rx_waddr = r_rx_tail;
        o_rx_raddr = r_rx_head;
        o_tx_waddr = r_tx_tail;
        o_tx_raddr = r_tx_head;
        o_pend     = '0;
        if (i_acc) begin
            case (i_mode)
                MODE_RX_BYTE: begin
                    // xoff decision uses the fill before this byte lands
                    if (over_thr && !r_flags[FLG_XOFF_OUT]) begin
                        n_flags[FLG_REQ_XOFF] = 1'b1;
                    end
                    if (rx_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        o_rx_we   = 1'b1;
                        n_rx_tail = (r_rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                         : r_rx_tail + 1'b1;
                        n_rx_fill = r_rx_fill + 1'b1;
                    end
                end
                MODE_HOST_WR: begin
                    if (!tx_full) begin
                        o_tx_we   = 1'b1;
                        n_tx_tail = (r_tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                         : r_tx_tail + 1'b1;
                        n_tx_fill = r_tx_fill + 1'b1;
                        o_pend.write_accepted = 1'b1;
                    end
                end
                MODE_HOST_RD: begin
                    if (r_flags[FLG_XOFF_OUT] && rx_empty) begin
                        n_flags[FLG_REQ_XON] = 1'b1;
                    end
                    if (!rx_empty) begin
                        o_rx_re   = 1'b1;
                        n_rx_head = (r_rx_head == RX_AW'(RX_DEPTH - 1)) ? '0
                                                                         : r_rx_head + 1'b1;
                        n_rx_fill = r_rx_fill - 1'b1;
                        o_pend.read_valid = 1'b1;
                    end
                end
                MODE_TX_RDY: begin
                    if (r_flags[FLG_REQ_XOFF]) begin
                        o_pend.line_valid = 1'b1;
                        o_pend.line_char  = CHAR_XOFF;
                        n_flags           = FLOW_XOFF_OUT;
                    end else if (r_flags[FLG_REQ_XON]) begin
                        o_pend.line_valid = 1'b1;
                        o_pend.line_char  = CHAR_XON;
                        n_flags           = FLOW_NONE;
                    end else if (!tx_empty) begin
                        o_tx_re   = 1'b1;
                        n_tx_head = (r_tx_head == TX_AW'(TX_DEPTH - 1)) ? '0
                                                                         : r_tx_head + 1'b1;
                        n_tx_fill = r_tx_fill - 1'b1;
                        o_pend.line_valid    = 1'b1;
                        o_pend.line_from_mem = 1'b1;
                    end
                end
                MODE_POLL: begin
                    if (r_flags[FLG_XOFF_OUT] && rx_empty) begin
                        n_flags[FLG_REQ_XON] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        o_pend.rx_count    = COUNT_W'(n_rx_fill);
        o_pend.rx_overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_rx_fill <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_fill <= '0;
            r_flags   <= FLOW_RESET;
            r_ovf     <= 1'b0;
            r_thr     <= THR_RESET;
        end else begin
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_rx_fill <= n_rx_fill;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_tx_fill <= n_tx_fill;
            r_flags   <= n_flags;
            r_ovf     <= n_ovf;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/uart_fifo_xon_xoff_flow_unit.sv -----
// top level of the uart buffering unit with xon/xoff receive flow control
// Each request on the slave stream (tuser = mode, tdata = data byte) yields exactly one result
// on the master stream. Requests are taken one per cycle while the master side keeps up. The
// request's cycle updates pointers, fill counts and flow flags, issues the fifo memory access
// and loads the pending stage; the pending stage then brings the registered memory read data
// into the output register. Both fifos live in single-port-per-direction memories with a
// registered read port, hence the pending stage. A stalled master side backs up through a pending
// stage and then drops o_s_tready. The receive and transmit stores hold no reset contents;
// only their pointers and counts are cleared, so no clearing pass runs after reset. Flow
// flags come out of reset with an xon request pending, so the first transmitter-ready request
// sends xon. The threshold register may only be written while no request is in flight.
`default_nettype none

module uart_fifo_xon_xoff_flow_unit import uflow_pkg::*; #(
    parameter int RX_DEPTH = DEF_RX_DEPTH,
    parameter int TX_DEPTH = DEF_TX_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // slave stream: requests
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,  // [7:0] data_byte
    input  wire logic [2:0]       i_s_tuser,  // [2:0] mode
    // master stream: results
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // [18] write_accepted, [25:19] rx_count, [26] rx_overflow, [31:27] zero
    output logic      [31:0]      o_m_tdata,
    // threshold register write
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);

    logic             acc;
    logic             p_move;
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [7:0]       rx_rdata, tx_rdata;
    t_pend            pend;

    // pending stage: result waiting for memory read data
    logic             r_p_valid;
    t_pend            r_p;
    // output register
    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic [31:0]      n_out_data;

    assign p_move     = r_p_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_p_valid || p_move;
    assign acc        = i_s_tvalid && o_s_tready;

    uflow_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_mode      (i_s_tuser),
        .o_rx_we     (rx_we),
        .o_rx_waddr  (rx_waddr),
        .o_rx_re     (rx_re),
        .o_rx_raddr  (rx_raddr),
        .o_tx_we     (tx_we),
        .o_tx_waddr  (tx_waddr),
        .o_tx_re     (tx_re),
        .o_tx_raddr  (tx_raddr),
        .o_pend      (pend)
    );

    // a pop never targets the entry pushed in the same cycle (fill was nonzero before),
    // and a push lands before any later pop reads it, so no forwarding is needed
    uflow_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    uflow_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    // read data register holds while the pending stage is stalled, since no new request
    // is taken then
    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = r_p.line_valid;
        n_out_data[8:1]   = r_p.line_from_mem ? tx_rdata : r_p.line_char;
        n_out_data[9]     = r_p.read_valid;
        n_out_data[17:10] = r_p.read_valid ? rx_rdata : 8'h00;
        n_out_data[18]    = r_p.write_accepted;
        n_out_data[25:19] = r_p.rx_count;
        n_out_data[26]    = r_p.rx_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p <= pend;
        end
        if (p_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- hdl/uflow_chk.sv -----
// port-level checker for the flow unit, bound to the top level
`default_nettype none
`include "uart_fifo_xon_xoff_flow_unit_defines.svh"

module uflow_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    // a stalled result stays offered and holds its data
    `UFLOW_ASSERT(a_hold_vld, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "valid dropped")
    `UFLOW_ASSERT(a_hold_dat, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "data moved")

    // a single request never both drives the line and returns a read byte
    `UFLOW_ASSERT(a_one_kind, o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[9]), "line and read")

    // an idle line reports a zero byte
    `UFLOW_ASSERT(a_lzero, o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[8:1] == 8'h00, "stray byte")

    // after a reset cycle nothing is pending and requests are taken
    `UFLOW_ASSERT_RST(a_after_rst, !i_rst_n |=> o_s_tready && !o_m_tvalid, "busy after reset")

endmodule

bind uart_fifo_xon_xoff_flow_unit uflow_chk u_uflow_chk (.*);

`default_nettype wire

// ----- sim/uart_fifo_xon_xoff_flow_unit_test.sv -----
// testbench for the xon/xoff uart flow unit: directed table, then random predicted episodes
`timescale 1ns / 100ps

module uart_fifo_xon_xoff_flow_unit_test;
    import uflow_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_WAIT  = 4;      // margin after the last result returns
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int PHASE_ITEMS  = 175;
    localparam int NUM_PHASES   = 7;
    localparam int IDLE_PCT     = 29;

    // mode codes the block ignores
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    // one result, laid out as on o_m_tdata (last field lowest)
    typedef struct packed {
        logic [4:0]         pad;
        logic               rx_overflow;
        logic [COUNT_W-1:0] rx_count;
        logic               write_accepted;
        logic [7:0]         read_byte;
        logic               read_valid;
        logic [7:0]         line_byte;
        logic               line_valid;
    } t_res;

    typedef enum logic {ROW_REQ, ROW_THR} t_row_kind;

    // one line of the directed table; a threshold row carries its value in data
    typedef struct packed {
        t_row_kind  kind;
        logic [2:0] mode;
        logic [7:0] data;
        logic       typed_in;
        t_res       want;
    } t_row;

    // traffic mixes for the random part
    typedef enum int {EP_RX_FLOOD, EP_RX_DRAIN, EP_TX_LOAD, EP_TX_DRAIN, EP_NOISE} t_ep;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_s_tvalid  = 1'b0;
    logic [7:0]       i_s_tdata   = 8'h00;
    logic [2:0]       i_s_tuser   = MODE_POLL;
    logic             i_m_tready  = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [THR_W-1:0] i_cfg_wdata = THR_RESET;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [31:0]      o_m_tdata;

    // typed expectation travels beside the request it belongs to
    logic row_typed_in  = 1'b0;
    t_res row_typed_res = '0;

    int unsigned src_idle_pct  = IDLE_PCT;
    int unsigned sink_idle_pct = IDLE_PCT;
    int unsigned mismatch_count = 0;
    int unsigned result_index   = 0;
    int unsigned quiet_cycles   = 0;

    // predictor state
    logic [7:0]         rx_q_mem [DEF_RX_DEPTH];
    logic [5:0]         rx_q_head = '0;
    logic [COUNT_W-1:0] rx_q_fill = '0;
    logic [7:0]         tx_q_mem [DEF_TX_DEPTH];
    logic [5:0]         tx_q_head = '0;
    logic [COUNT_W-1:0] tx_q_fill = '0;
    logic [2:0]         flow_state    = FLOW_RESET;
    logic               overflow_seen = 1'b0;
    logic [THR_W-1:0]   thr_shadow    = THR_RESET;

    t_res flow_results_due [$];
    t_row dir_rows [$];

    uart_fifo_xon_xoff_flow_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side stalls at random
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // one request through the flow unit: fifos, flags and the result it yields
    task automatic flow_unit_step(input logic [2:0] mode, input logic [7:0] data,
                                  output t_res r);
        logic [5:0] slot;
        r = '0;
        case (mode)
            MODE_RX_BYTE: begin
                // xoff check comes before the full check, as for any received byte
                if (rx_q_fill > thr_shadow && !flow_state[FLG_XOFF_OUT])
                    flow_state[FLG_REQ_XOFF] = 1'b1;
                if (rx_q_fill >= DEF_RX_DEPTH) begin
                    overflow_seen = 1'b1;
                end else begin
                    slot = rx_q_head + rx_q_fill[5:0];
                    rx_q_mem[slot] = data;
                    rx_q_fill++;
                end
            end
            MODE_HOST_WR: begin
                if (tx_q_fill < DEF_TX_DEPTH) begin
                    slot = tx_q_head + tx_q_fill[5:0];
                    tx_q_mem[slot] = data;
                    tx_q_fill++;
                    r.write_accepted = 1'b1;
                end
            end
            MODE_HOST_RD, MODE_POLL: begin
                // empty receive side after an xoff went out asks for xon
                if (flow_state[FLG_XOFF_OUT] && rx_q_fill == 0)
                    flow_state[FLG_REQ_XON] = 1'b1;
                if (mode == MODE_HOST_RD && rx_q_fill != 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_q_mem[rx_q_head];
                    rx_q_head++;
                    rx_q_fill--;
                end
            end
            MODE_TX_RDY: begin
                // xoff first, then xon, then queued data
                if (flow_state[FLG_REQ_XOFF]) begin
                    r.line_valid = 1'b1;
                    r.line_byte  = CHAR_XOFF;
                    flow_state   = FLOW_XOFF_OUT;
                end else if (flow_state[FLG_REQ_XON]) begin
                    r.line_valid = 1'b1;
                    r.line_byte  = CHAR_XON;
                    flow_state   = FLOW_NONE;
                end else if (tx_q_fill != 0) begin
                    r.line_valid = 1'b1;
                    r.line_byte  = tx_q_mem[tx_q_head];
                    tx_q_head++;
                    tx_q_fill--;
                end
            end
            default: ;
        endcase
        r.rx_count    = rx_q_fill;
        r.rx_overflow = overflow_seen;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch in %s: got 0x%0h, want 0x%0h (result %0d)",
                 what, got, want, result_index);
        mismatch_count++;
    endtask

    // predict on request, compare on result
    always @(posedge i_clk) begin : result_check
        t_res pred;
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                flow_unit_step(i_s_tuser, i_s_tdata, pred);
                flow_results_due.push_back(row_typed_in ? row_typed_res : pred);
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (flow_results_due.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, 0);
                end else begin
                    want = flow_results_due.pop_front();
                    if (got.line_valid !== want.line_valid)
                        report_mismatch("line_valid", got.line_valid, want.line_valid);
                    if (got.line_byte !== want.line_byte)
                        report_mismatch("line_byte", got.line_byte, want.line_byte);
                    if (got.read_valid !== want.read_valid)
                        report_mismatch("read_valid", got.read_valid, want.read_valid);
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", got.read_byte, want.read_byte);
                    if (got.write_accepted !== want.write_accepted)
                        report_mismatch("write_accepted", got.write_accepted,
                                        want.write_accepted);
                    if (got.rx_count !== want.rx_count)
                        report_mismatch("rx_count", got.rx_count, want.rx_count);
                    if (got.rx_overflow !== want.rx_overflow)
                        report_mismatch("rx_overflow", got.rx_overflow, want.rx_overflow);
                    if (got.pad !== want.pad)
                        report_mismatch("tdata padding", got.pad, want.pad);
                end
                result_index++;
            end
        end
    end

    // stall guard: no handshake on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_res res_of(input logic lv, input logic [7:0] lb, input logic rv,
                                    input logic [7:0] rb, input logic wa,
                                    input logic [COUNT_W-1:0] cnt, input logic ovf);
        t_res r;
        r = '0;
        r.line_valid     = lv;
        r.line_byte      = lb;
        r.read_valid     = rv;
        r.read_byte      = rb;
        r.write_accepted = wa;
        r.rx_count       = cnt;
        r.rx_overflow    = ovf;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [2:0] mode, input logic [7:0] data,
                                       input t_res want);
        t_row row;
        row.kind     = ROW_REQ;
        row.mode     = mode;
        row.data     = data;
        row.typed_in = 1'b1;
        row.want     = want;
        return row;
    endfunction

    function automatic t_row req_row(input logic [2:0] mode, input logic [7:0] data);
        t_row row;
        row = typed_row(mode, data, '0);
        row.typed_in = 1'b0;
        return row;
    endfunction

    function automatic t_row thr_row(input logic [THR_W-1:0] value);
        t_row row;
        row = req_row(MODE_POLL, {1'b0, value});
        row.kind = ROW_THR;
        return row;
    endfunction

    // traffic mix per episode kind
    function automatic logic [2:0] pick_mode(input t_ep ep);
        int unsigned roll;
        roll = $urandom_range(99);
        case (ep)
            EP_RX_FLOOD:
                pick_mode = roll < 85 ? MODE_RX_BYTE : roll < 95 ? MODE_TX_RDY : MODE_POLL;
            EP_RX_DRAIN:
                pick_mode = roll < 65 ? MODE_HOST_RD : roll < 80 ? MODE_POLL :
                            roll < 95 ? MODE_TX_RDY : MODE_RX_BYTE;
            EP_TX_LOAD:
                pick_mode = roll < 80 ? MODE_HOST_WR : MODE_TX_RDY;
            EP_TX_DRAIN:
                pick_mode = roll < 75 ? MODE_TX_RDY : roll < 90 ? MODE_HOST_WR : MODE_HOST_RD;
            default:
                pick_mode = 3'($urandom_range(7));
        endcase
    endfunction

    // present one request, with random gaps ahead of it, and wait until it is taken
    task automatic send_request(input logic [2:0] mode, input logic [7:0] data,
                                input logic typed_in, input t_res want);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid    <= 1'b1;
        i_s_tuser     <= mode;
        i_s_tdata     <= data;
        row_typed_in  <= typed_in;
        row_typed_res <= want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // hold off until every outstanding result is back and the pipe is empty
    task automatic settle;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (flow_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_shadow   = value;
    endtask

    initial begin
        logic [2:0]  mode;
        t_ep         ep;
        int unsigned ep_len;
        int unsigned sent;
        logic [THR_W-1:0] thr;

        // straight out of reset: xon pending, fifos empty, threshold at its reset value
        dir_rows.push_back(typed_row(MODE_TX_RDY, 8'h00, res_of(1, CHAR_XON, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_TX_RDY, 8'h00, res_of(0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_HOST_RD, 8'h00, res_of(0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_POLL, 8'hFF, res_of(0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_HOST_WR, 8'h00, res_of(0, 0, 0, 0, 1, 0, 0)));
        dir_rows.push_back(typed_row(MODE_HOST_WR, 8'hFF, res_of(0, 0, 0, 0, 1, 0, 0)));
        dir_rows.push_back(typed_row(MODE_TX_RDY, 8'h00, res_of(1, 8'h00, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_TX_RDY, 8'h00, res_of(1, 8'hFF, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_RX_BYTE, 8'hFF, res_of(0, 0, 0, 0, 0, 1, 0)));
        dir_rows.push_back(typed_row(MODE_RX_BYTE, 8'h00, res_of(0, 0, 0, 0, 0, 2, 0)));
        dir_rows.push_back(typed_row(MODE_HOST_RD, 8'h00, res_of(0, 0, 1, 8'hFF, 0, 1, 0)));
        dir_rows.push_back(typed_row(MODE_HOST_RD, 8'hFF, res_of(0, 0, 1, 8'h00, 0, 0, 0)));
        // unused modes do nothing
        dir_rows.push_back(typed_row(MODE_SPARE_5, 8'h5A, res_of(0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_SPARE_6, 8'hA5, res_of(0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(MODE_SPARE_7, 8'hFF, res_of(0, 0, 0, 0, 0, 0, 0)));
        // threshold zero: one full xoff / xon round trip
        dir_rows.push_back(thr_row(7'd0));
        dir_rows.push_back(req_row(MODE_RX_BYTE, 8'h5A));
        dir_rows.push_back(req_row(MODE_RX_BYTE, 8'h3C));
        dir_rows.push_back(req_row(MODE_TX_RDY, 8'h00));
        dir_rows.push_back(req_row(MODE_RX_BYTE, 8'h96));
        dir_rows.push_back(req_row(MODE_HOST_RD, 8'h00));
        dir_rows.push_back(req_row(MODE_HOST_RD, 8'h00));
        dir_rows.push_back(req_row(MODE_POLL, 8'h00));
        dir_rows.push_back(req_row(MODE_HOST_RD, 8'h00));
        dir_rows.push_back(req_row(MODE_POLL, 8'h00));
        dir_rows.push_back(req_row(MODE_TX_RDY, 8'h00));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_THR) begin
                settle();
                write_threshold(dir_rows[i].data[THR_W-1:0]);
            end else begin
                send_request(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].typed_in,
                             dir_rows[i].want);
            end
        end

        // random episodes, one threshold per phase, reset value first, then the extremes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       thr = THR_RESET;
                1:       thr = 7'd0;
                2:       thr = 7'd64;
                3:       thr = 7'd63;
                4:       thr = 7'd1;
                default: thr = THR_W'($urandom_range(64));
            endcase
            settle();
            write_threshold(thr);
            // one phase runs back to back on both sides
            src_idle_pct  = (ph == 2) ? 0 : IDLE_PCT;
            sink_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                ep     = t_ep'($urandom_range(4));
                ep_len = $urandom_range(80, 8);
                for (int k = 0; k < ep_len && sent < PHASE_ITEMS; k++) begin
                    mode = pick_mode(ep);
                    send_request(mode, 8'($urandom_range(255)), 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
